### rtl/core/snt_pkg.sv
package snt_pkg;

    localparam int unsigned SLOT_COUNT_DEF  = 8;
    localparam int unsigned MAX_RESULTS     = 8;
    localparam logic [31:0] TIMEOUT_RESET   = 32'd30000;
    localparam logic [7:0]  CIN_NOTE_OFF    = 8'h08;
    localparam logic [7:0]  STATUS_NOTE_OFF = 8'h80;
    localparam logic [6:0]  RELEASE_VEL     = 7'd0;
    localparam int unsigned PADDR_W         = 3;

    typedef enum logic [1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_SCAN     = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLAIM,
        ST_WALK,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [3:0]  channel;
        logic [6:0]  note;
        logic [31:0] start_time;
    } slot_entry_t;

    typedef struct packed {
        logic expired;
        logic match;
    } cmp_res_t;

endpackage

### rtl/core/snt_slot_mem.sv
module snt_slot_mem #(
    parameter int unsigned SLOT_COUNT = 8,
    parameter int unsigned IDX_W      = 3
) (
    input  logic                clk,
    input  logic                we,
    input  logic [IDX_W-1:0]    waddr,
    input  snt_pkg::slot_entry_t wdata,
    input  logic                re,
    input  logic [IDX_W-1:0]    raddr,
    output snt_pkg::slot_entry_t rdata
);
    import snt_pkg::*;

    slot_entry_t mem [SLOT_COUNT];
    slot_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/snt_cmp_unit.sv
module snt_cmp_unit (
    input  snt_pkg::slot_entry_t entry,
    input  logic [31:0]          now_ms,
    input  logic [31:0]          timeout_ms,
    input  logic [3:0]           channel,
    input  logic [6:0]           note,
    output snt_pkg::cmp_res_t    res
);
    import snt_pkg::*;

    logic [31:0] elapsed;

    // wrapping subtraction keeps the age right across a timer rollover
    assign elapsed     = now_ms - entry.start_time;
    assign res.expired = (elapsed >= timeout_ms);
    assign res.match   = (entry.channel == channel) && (entry.note == note);

endmodule

### rtl/core/stuck_note_timeout_tracker.sv
// Stuck-note tracker: SLOT_COUNT slots in a small memory, visited one per cycle unless stalled.
// Note on: a walk of the valid bits to the lowest free slot; a full table drops the note.
// Note off: one read and compare per slot, ends at a match.
// Scan: one read and compare per slot, then a drain of the held packet; output stalls hold both.
// One request at a time: req_stall is high until the block is idle; a single compare unit.
// Reset clears all slot valid bits at once and sets timeout_ms to 30000.
module stuck_note_timeout_tracker #(
    parameter int unsigned SLOT_COUNT = snt_pkg::SLOT_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [snt_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic [1:0]                  opcode,
    input  logic [3:0]                  channel,
    input  logic [6:0]                  note,
    input  logic [31:0]                 now_ms,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output logic [7:0]                  code_index,
    output logic [7:0]                  status_byte,
    output logic [6:0]                  released_note,
    output logic [6:0]                  velocity,
    output logic                        last
);
    import snt_pkg::*;

    localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_RESULTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    state_t             state_reg, state_next;
    opcode_t            op_reg;
    logic [3:0]         ch_reg;
    logic [6:0]         note_reg;
    logic [31:0]        now_reg;
    logic [31:0]        timeout_reg;

    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               iss_live_reg, iss_live_next;
    logic               chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic [SLOT_COUNT-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic               pend_vld_reg, pend_vld_next;
    logic [3:0]         pend_ch_reg, pend_ch_next;
    logic [6:0]         pend_note_reg, pend_note_next;

    logic               out_vld_reg, out_vld_next;
    logic [3:0]         out_ch_reg, out_ch_next;
    logic [6:0]         out_note_reg, out_note_next;
    logic               out_last_reg, out_last_next;

    logic               mem_we;
    logic               mem_re;
    slot_entry_t        mem_wdata;
    slot_entry_t        mem_rdata;
    cmp_res_t           cmp_res;

    logic               accept;
    logic               cfg_wr;
    logic               out_free;
    logic               hit_scan;
    logic               hit_off;
    logic               blocked;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[PADDR_W-1];
    assign prdata = paddr[PADDR_W-1] ? 32'd0 : timeout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wr)
        begin
            timeout_reg <= pwdata;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;

    // latch the request fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode_t'(opcode);
            ch_reg   <= channel;
            note_reg <= note;
            now_reg  <= now_ms;
        end
    end

    assign mem_wdata.channel    = ch_reg;
    assign mem_wdata.note       = note_reg;
    assign mem_wdata.start_time = now_reg;

    snt_slot_mem #(
        .SLOT_COUNT (SLOT_COUNT),
        .IDX_W      (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (idx_reg),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (idx_reg),
        .rdata (mem_rdata)
    );

    snt_cmp_unit u_cmp (
        .entry      (mem_rdata),
        .now_ms     (now_reg),
        .timeout_ms (timeout_reg),
        .channel    (ch_reg),
        .note       (note_reg),
        .res        (cmp_res)
    );

    assign out_free = !out_vld_reg || !rsp_stall;
    assign hit_scan = (op_reg == OP_SCAN) && chk_vld_reg && valid_reg[chk_idx_reg]
                      && cmp_res.expired && (cnt_reg < CNT_W'(MAX_RESULTS));
    assign hit_off  = (op_reg == OP_NOTE_OFF) && chk_vld_reg && valid_reg[chk_idx_reg]
                      && cmp_res.match;
    // a second expired slot must push the held packet out first
    assign blocked  = hit_scan && pend_vld_reg && !out_free;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        iss_live_next  = iss_live_reg;
        chk_vld_next   = chk_vld_reg;
        chk_idx_next   = chk_idx_reg;
        valid_next     = valid_reg;
        cnt_next       = cnt_reg;
        pend_vld_next  = pend_vld_reg;
        pend_ch_next   = pend_ch_reg;
        pend_note_next = pend_note_reg;
        out_vld_next   = out_vld_reg;
        out_ch_next    = out_ch_reg;
        out_note_next  = out_note_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        if (out_vld_reg && !rsp_stall)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next      = '0;
                    iss_live_next = 1'b1;
                    chk_vld_next  = 1'b0;
                    cnt_next      = '0;
                    pend_vld_next = 1'b0;
                    unique case (opcode)
                        OP_NOTE_ON:  state_next = ST_CLAIM;
                        OP_NOTE_OFF: state_next = ST_WALK;
                        OP_SCAN:     state_next = ST_WALK;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end

            ST_CLAIM:
            begin
                if (!valid_reg[idx_reg])
                begin
                    mem_we              = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    state_next          = ST_IDLE;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    // table full: drop the note
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_WALK:
            begin
                if (!iss_live_reg && !chk_vld_reg)
                begin
                    state_next = (op_reg == OP_SCAN) ? ST_FLUSH : ST_IDLE;
                end
                else if (hit_off)
                begin
                    valid_next[chk_idx_reg] = 1'b0;
                    state_next              = ST_IDLE;
                end
                else if (!blocked)
                begin
                    if (hit_scan)
                    begin
                        valid_next[chk_idx_reg] = 1'b0;
                        cnt_next                = cnt_reg + 1'b1;
                        if (pend_vld_reg)
                        begin
                            out_vld_next  = 1'b1;
                            out_ch_next   = pend_ch_reg;
                            out_note_next = pend_note_reg;
                            out_last_next = 1'b0;
                        end
                        pend_vld_next  = 1'b1;
                        pend_ch_next   = mem_rdata.channel;
                        pend_note_next = mem_rdata.note;
                    end
                    // advance the read pipeline
                    if (iss_live_reg)
                    begin
                        mem_re       = 1'b1;
                        chk_vld_next = 1'b1;
                        chk_idx_next = idx_reg;
                        if (idx_reg == LAST_IDX)
                        begin
                            iss_live_next = 1'b0;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        chk_vld_next = 1'b0;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (!pend_vld_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_ch_next   = pend_ch_reg;
                    out_note_next = pend_note_reg;
                    out_last_next = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            iss_live_reg <= 1'b0;
            chk_vld_reg  <= 1'b0;
            chk_idx_reg  <= '0;
            valid_reg    <= '0;
            cnt_reg      <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            iss_live_reg <= iss_live_next;
            chk_vld_reg  <= chk_vld_next;
            chk_idx_reg  <= chk_idx_next;
            valid_reg    <= valid_next;
            cnt_reg      <= cnt_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_ch_reg   <= pend_ch_next;
        pend_note_reg <= pend_note_next;
        out_ch_reg    <= out_ch_next;
        out_note_reg  <= out_note_next;
        out_last_reg  <= out_last_next;
    end

    assign rsp_valid     = out_vld_reg;
    assign code_index    = CIN_NOTE_OFF;
    assign status_byte   = STATUS_NOTE_OFF | {4'd0, out_ch_reg};
    assign released_note = out_note_reg;
    assign velocity      = RELEASE_VEL;
    assign last          = out_last_reg;

endmodule

### bench/tb.sv
typedef struct packed {
    logic [7:0] cin;
    logic [7:0] status;
    logic [6:0] pitch;
    logic [6:0] vel;
    logic       tail;
} note_off_t;

class note_slot_tracker;
    logic [31:0] timeout_ms;
    bit          used    [snt_pkg::SLOT_COUNT_DEF];
    logic [3:0]  chan    [snt_pkg::SLOT_COUNT_DEF];
    logic [6:0]  pitch   [snt_pkg::SLOT_COUNT_DEF];
    logic [31:0] started [snt_pkg::SLOT_COUNT_DEF];
    note_off_t   due_note_offs [$];
    int unsigned mismatches;

    function new();
        timeout_ms = snt_pkg::TIMEOUT_RESET;
        foreach (used[i])
        begin
            used[i] = 1'b0;
        end
        mismatches = 0;
    endfunction

    function int pick_used();
        int held [$];
        foreach (used[i])
        begin
            if (used[i])
                held.push_back(i);
        end
        if (held.size() == 0)
            return -1;
        return held[$urandom_range(0, held.size() - 1)];
    endfunction

    // Apply one accepted request to the slot table and queue the note offs it causes.
    function void take_request(logic [1:0] op, logic [3:0] ch, logic [6:0] nt,
                               logic [31:0] now);
        note_off_t   batch [$];
        note_off_t   pkt;
        logic [31:0] elapsed;
        bit          done;
        done = 1'b0;
        case (op)
            snt_pkg::OP_NOTE_ON:
                for (int i = 0; i < snt_pkg::SLOT_COUNT_DEF && !done; i++)
                begin
                    if (!used[i])
                    begin
                        used[i]    = 1'b1;
                        chan[i]    = ch;
                        pitch[i]   = nt;
                        started[i] = now;
                        done       = 1'b1;
                    end
                end
            snt_pkg::OP_NOTE_OFF:
                for (int i = 0; i < snt_pkg::SLOT_COUNT_DEF && !done; i++)
                begin
                    if (used[i] && chan[i] == ch && pitch[i] == nt)
                    begin
                        used[i] = 1'b0;
                        done    = 1'b1;
                    end
                end
            snt_pkg::OP_SCAN:
            begin
                for (int i = 0; i < snt_pkg::SLOT_COUNT_DEF &&
                     batch.size() < snt_pkg::MAX_RESULTS; i++)
                begin
                    elapsed = now - started[i];
                    if (used[i] && elapsed >= timeout_ms)
                    begin
                        pkt.cin    = snt_pkg::CIN_NOTE_OFF;
                        pkt.status = snt_pkg::STATUS_NOTE_OFF | {4'h0, chan[i]};
                        pkt.pitch  = pitch[i];
                        pkt.vel    = snt_pkg::RELEASE_VEL;
                        pkt.tail   = 1'b0;
                        batch.push_back(pkt);
                        used[i] = 1'b0;
                    end
                end
                if (batch.size() > 0)
                    batch[batch.size() - 1].tail = 1'b1;
                foreach (batch[i])
                begin
                    due_note_offs.push_back(batch[i]);
                end
            end
            default:
                ;
        endcase
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    function void check_release(note_off_t got);
        note_off_t want;
        if (due_note_offs.size() == 0)
        begin
            $display("%0t: unexpected note off expected none got %0h", $time, got);
            mismatches++;
        end
        else
        begin
            want = due_note_offs.pop_front();
            report("code_index", 32'(want.cin), 32'(got.cin));
            report("status_byte", 32'(want.status), 32'(got.status));
            report("released_note", 32'(want.pitch), 32'(got.pitch));
            report("velocity", 32'(want.vel), 32'(got.vel));
            report("last", 32'(want.tail), 32'(got.tail));
        end
    endfunction
endclass

module tb;
    import snt_pkg::*;

    localparam int unsigned SLOTS          = SLOT_COUNT_DEF;
    localparam int unsigned HOLD_CYCLES    = 200;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam logic [PADDR_W-1:0] REG_TIMEOUT_MS = '0;

    logic               clk;
    logic               rst_n   = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               req_valid = 1'b0;
    logic               req_stall;
    logic [1:0]         opcode  = '0;
    logic [3:0]         channel = '0;
    logic [6:0]         note    = '0;
    logic [31:0]        now_ms  = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic [7:0]         code_index;
    logic [7:0]         status_byte;
    logic [6:0]         released_note;
    logic [6:0]         velocity;
    logic               last_pkt;

    note_slot_tracker notes = new();
    bit          calm     = 1'b0;
    bit          hold_req = 1'b0;
    logic [31:0] sim_ms;

    stuck_note_timeout_tracker dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .req_valid(req_valid), .req_stall(req_stall),
        .opcode(opcode), .channel(channel), .note(note), .now_ms(now_ms),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .code_index(code_index), .status_byte(status_byte),
        .released_note(released_note), .velocity(velocity), .last(last_pkt)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            notes.check_release(note_off_t'({code_index, status_byte, released_note,
                                              velocity, last_pkt}));
    end

    // Receiver: random stall bursts, one long hold-off on request, none in the tail.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                rsp_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                rsp_stall <= 1'b0;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("stuck_note_timeout_tracker regression: fail");
        $finish;
    end

    task automatic offer(input logic [1:0] op, input logic [3:0] ch, input logic [6:0] nt,
                         input logic [31:0] now);
        int unsigned gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        opcode    <= op;
        channel   <= ch;
        note      <= nt;
        now_ms    <= now;
        do
            @(posedge clk);
        while (req_stall);
        notes.take_request(op, ch, nt, now);
    endtask

    // Drop valid, drain every note off, then give the last request time to finish.
    task automatic settle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (notes.due_note_offs.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [31:0] value);
        settle();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_TIMEOUT_MS;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        notes.timeout_ms = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_directed();
        logic [31:0] t0;
        t0 = 32'hFFFF_F000;
        offer(OP_NOTE_ON, 4'd0, 7'd0, t0);
        offer(OP_NOTE_ON, 4'd15, 7'd127, t0 + 1);
        offer(OP_NOTE_ON, 4'd15, 7'd127, t0 + 2);
        for (int i = 1; i <= 5; i++)
            offer(OP_NOTE_ON, 4'(i), 7'(i * 20), t0 + 100);
        // table full: dropped
        offer(OP_NOTE_ON, 4'd7, 7'd64, t0 + 150);
        offer(OP_NOTE_OFF, 4'd9, 7'd9, 32'hFFFF_FFFF);
        offer(OP_NOTE_OFF, 4'd15, 7'd127, 32'd0);
        offer(OP_NOTE_ON, 4'd3, 7'd99, t0 + 200);
        offer(OP_UNUSED, 4'd15, 7'd127, 32'hFFFF_FFFF);
        // one short of the timeout, then exactly on it across the wrap
        offer(OP_SCAN, 4'd0, 7'd0, t0 + 29999);
        offer(OP_SCAN, 4'd15, 7'd127, t0 + 30000);
        offer(OP_SCAN, 4'd0, 7'd0, t0 + 30200);
        for (int i = 0; i < SLOTS; i++)
            offer(OP_NOTE_ON, 4'(15 - i), 7'(127 - i), 32'd0);
        offer(OP_SCAN, 4'd0, 7'd0, 32'd30000);
    endtask

    task automatic random_burst(input int unsigned count, input int unsigned step_max);
        int unsigned counted;
        int          pick;
        int          slot;
        logic [1:0]  op;
        logic [3:0]  ch;
        logic [6:0]  nt;
        logic [31:0] now;
        counted = 0;
        while (counted < count)
        begin
            pick = $urandom_range(0, 99);
            ch   = 4'($urandom_range(0, 15));
            nt   = 7'($urandom_range(0, 127));
            now  = sim_ms;
            slot = notes.pick_used();
            if (pick < 40)
            begin
                op = OP_NOTE_ON;
                if (slot >= 0 && $urandom_range(0, 2) == 0)
                begin
                    ch = notes.chan[slot];
                    nt = notes.pitch[slot];
                end
            end
            else if (pick < 62)
            begin
                op  = OP_NOTE_OFF;
                now = $urandom;
                if (slot >= 0 && $urandom_range(0, 4) != 0)
                begin
                    ch = notes.chan[slot];
                    nt = notes.pitch[slot];
                end
            end
            else if (pick < 95)
            begin
                op = OP_SCAN;
                case ($urandom_range(0, 9))
                    0: now = $urandom;
                    1: if (slot >= 0) now = notes.started[slot] + notes.timeout_ms;
                    2: if (slot >= 0) now = notes.started[slot] + notes.timeout_ms - 1;
                    default: ;
                endcase
            end
            else
            begin
                op  = OP_UNUSED;
                now = $urandom;
            end
            offer(op, ch, nt, now);
            if (op != OP_UNUSED)
                counted++;
            sim_ms = sim_ms + $urandom_range(0, step_max);
        end
    endtask

    initial
    begin
        logic [31:0] limit_ms;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        sim_ms = $urandom;

        run_directed();
        random_burst(60, 12000);

        write_timeout(32'd0);
        random_burst(20, 50);
        for (int i = 0; i < 6; i++)
            offer(OP_NOTE_ON, 4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)), sim_ms);
        // hold the output so the block backs up onto its request side
        hold_req = 1'b1;
        random_burst(30, 50);

        write_timeout(32'hFFFF_FFFF);
        random_burst(60, 1000);

        limit_ms = $urandom_range(100, 5000);
        write_timeout(limit_ms);
        random_burst(70, limit_ms / 2);

        calm = 1'b1;
        limit_ms = $urandom_range(1000, 40000);
        write_timeout(limit_ms);
        random_burst(80, limit_ms / 3);

        settle();
        if (notes.mismatches == 0)
            $display("stuck_note_timeout_tracker regression: pass");
        else
            $display("stuck_note_timeout_tracker regression: fail");
        $finish;
    end
endmodule

### filelist.f
rtl/core/snt_pkg.sv
rtl/core/snt_slot_mem.sv
rtl/core/snt_cmp_unit.sv
rtl/core/stuck_note_timeout_tracker.sv
bench/tb.sv
